// File: sv/nearest_neighbor_resampler_defines.svh
// Assertion macros shared by the checker of the nearest-neighbor resampler.
`ifndef NEAREST_NEIGHBOR_RESAMPLER_DEFINES_SVH
`define NEAREST_NEIGHBOR_RESAMPLER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while reset is asserted.
`define NNR_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("nnr check failed");

// Next-cycle implication, sampled on clk and disabled while reset is asserted.
`define NNR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("nnr check failed");

`endif

// File: sv/nnr_pkg.sv
// Types and constants shared by the nearest-neighbor resampler modules.
package nnr_pkg;

	localparam int ACCUM_W     = 32;
	localparam int FRAC_BITS   = 8;
	localparam int STEP_W      = 13;
	localparam int TOTAL_W     = 24;
	localparam int SAMPLE_W    = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 24;
	localparam int MAX_RESULTS = 64;
	localparam int RUN_CNT_W   = $clog2(MAX_RESULTS);
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [STEP_W-1:0] STEP_RESET    = 13'd256;
	localparam logic [7:0]        UNSIGNED_BIAS = 8'h80;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PHASE_STEP,
		REG_SOURCE_WIDE,
		REG_RESULT_WIDE,
		REG_OUTPUT_TOTAL
	} reg_idx_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] value;
		logic                       first;
	} item_t;

	typedef struct packed {
		logic [STEP_W-1:0]  phase_step;
		logic [TOTAL_W-1:0] output_total;
	} cfg_t;

endpackage

// File: sv/nearest_neighbor_resampler.sv
// Nearest-neighbor sample-rate converter: top level joining front end, queue and output engine.
// Source samples enter on in_valid/in_stall with raw_sample and first_sample; a transfer
// happens on a clock edge with in_valid high and in_stall low. Results leave on
// out_valid/out_stall with out_value, run_end and sound_done. Registers are written over
// cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is always high.
// An accepted sample is converted at once and waits in a two-entry queue. The output engine
// takes one sample at a time; its accumulator add and position compare allow one result per
// cycle while the receiver does not stall. With the block idle, the first result of a sample
// passes the queue and the current-sample register before the output register presents it.
// Up to 64 results follow one sample, and run_end marks the last of them.
// When the receiver stalls, the output register holds its result and the engine waits;
// once the queue is full, in_stall rises. Reset clears the counters, the queue and the output
// valid flag, and sets the phase step to 256 with all other configuration registers zero.
module nearest_neighbor_resampler #(
	parameter int COUNT_BITS = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [nnr_pkg::SAMPLE_W-1:0]        raw_sample,
	input  logic                                first_sample,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [nnr_pkg::SAMPLE_W-1:0] out_value,
	output logic                                run_end,
	output logic                                sound_done,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [nnr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [nnr_pkg::CFG_DATA_W-1:0]      cfg_data
);

	nnr_pkg::item_t front_item;
	nnr_pkg::item_t head;
	nnr_pkg::cfg_t  cfg;
	logic           full;
	logic           push;
	logic           pop;
	logic           head_valid;

	assign in_stall = full;
	assign push     = in_valid && !full;

	nnr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.raw_sample   (raw_sample),
		.first_sample (first_sample),
		.item         (front_item),
		.cfg          (cfg)
	);

	nnr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (front_item),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	nnr_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.q_valid    (head_valid),
		.q_head     (head),
		.q_pop      (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_value  (out_value),
		.run_end    (run_end),
		.sound_done (sound_done)
	);

endmodule

// File: sv/nnr_front.sv
// Front end: configuration registers and conversion of source samples to result format.
module nnr_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [nnr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [nnr_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic [nnr_pkg::SAMPLE_W-1:0]        raw_sample,
	input  logic                                first_sample,
	output nnr_pkg::item_t                      item,
	output nnr_pkg::cfg_t                       cfg
);

	logic [nnr_pkg::STEP_W-1:0]   phase_step_q;
	logic [nnr_pkg::TOTAL_W-1:0]  output_total_q;
	logic                         source_wide_q;
	logic                         result_wide_q;
	logic [nnr_pkg::SAMPLE_W-1:0] wide;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q   <= nnr_pkg::STEP_RESET;
			output_total_q <= '0;
			source_wide_q  <= 1'b0;
			result_wide_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (nnr_pkg::reg_idx_t'(cfg_index))
				nnr_pkg::REG_PHASE_STEP: begin
					phase_step_q <= cfg_data[nnr_pkg::STEP_W-1:0];
				end
				nnr_pkg::REG_SOURCE_WIDE: begin
					source_wide_q <= cfg_data[0];
				end
				nnr_pkg::REG_RESULT_WIDE: begin
					result_wide_q <= cfg_data[0];
				end
				nnr_pkg::REG_OUTPUT_TOTAL: begin
					output_total_q <= cfg_data[nnr_pkg::TOTAL_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// An 8-bit source is unsigned; flipping the top bit removes the offset of 128.
	always_comb begin
		if (source_wide_q) begin
			wide = raw_sample;
		end else begin
			wide = {raw_sample[7:0] ^ nnr_pkg::UNSIGNED_BIAS, 8'h00};
		end
		if (result_wide_q) begin
			item.value = wide;
		end else begin
			item.value = {{8{wide[15]}}, wide[15:8]};
		end
		item.first = first_sample;
	end

	assign cfg.phase_step   = phase_step_q;
	assign cfg.output_total = output_total_q;

endmodule

// File: sv/nnr_queue.sv
// Short queue of converted items between the front end and the output engine.
module nnr_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  nnr_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output nnr_pkg::item_t head
);

	nnr_pkg::item_t                  entries_q [nnr_pkg::QUEUE_DEPTH];
	logic [nnr_pkg::QUEUE_PTR_W-1:0] wr_q;
	logic [nnr_pkg::QUEUE_PTR_W-1:0] rd_q;
	logic [nnr_pkg::QUEUE_CNT_W-1:0] cnt_q;

	assign full       = (cnt_q == nnr_pkg::QUEUE_CNT_W'(nnr_pkg::QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = entries_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_q] <= push_item;
		end
	end

	// The depth is a power of two, so the pointers wrap on their own.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + nnr_pkg::QUEUE_PTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + nnr_pkg::QUEUE_PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + nnr_pkg::QUEUE_CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - nnr_pkg::QUEUE_CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: sv/nnr_back.sv
// Output engine: phase accumulator, source index and output counter, one result per cycle unless stalled.
module nnr_back #(
	parameter int COUNT_BITS = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  nnr_pkg::cfg_t                       cfg,
	input  logic                                q_valid,
	input  nnr_pkg::item_t                      q_head,
	output logic                                q_pop,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [nnr_pkg::SAMPLE_W-1:0] out_value,
	output logic                                run_end,
	output logic                                sound_done
);

	localparam int CMP_W = (COUNT_BITS > nnr_pkg::TOTAL_W) ? COUNT_BITS : nnr_pkg::TOTAL_W;

	logic [nnr_pkg::ACCUM_W-1:0]       accum_q;
	logic [COUNT_BITS-1:0]             index_q;
	logic [COUNT_BITS-1:0]             made_q;
	logic [nnr_pkg::RUN_CNT_W-1:0]     run_cnt_q;
	logic                              cur_valid_q;
	logic signed [nnr_pkg::SAMPLE_W-1:0] cur_value_q;

	logic [nnr_pkg::ACCUM_W-1:0] accum_nxt;
	logic [COUNT_BITS-1:0]       pos_cur;
	logic [COUNT_BITS-1:0]       pos_nxt;
	logic [COUNT_BITS-1:0]       made_nxt;
	logic [CMP_W-1:0]            total_ext;
	logic                        hit;
	logic                        more;
	logic                        emit;
	logic                        finish;

	assign accum_nxt = accum_q + nnr_pkg::ACCUM_W'(cfg.phase_step);
	assign pos_cur   = COUNT_BITS'(accum_q >> nnr_pkg::FRAC_BITS);
	assign pos_nxt   = COUNT_BITS'(accum_nxt >> nnr_pkg::FRAC_BITS);
	assign made_nxt  = made_q + COUNT_BITS'(1);
	assign total_ext = CMP_W'(cfg.output_total);

	// The current state yields an output; more tells whether the state after it yields
	// another one for the same source sample within the cap of 64 results, which marks the end of the run early.
	assign hit  = (CMP_W'(made_q) < total_ext) && (pos_cur == index_q);
	assign more = (run_cnt_q != nnr_pkg::RUN_CNT_W'(nnr_pkg::MAX_RESULTS - 1))
		&& (CMP_W'(made_nxt) < total_ext) && (pos_nxt == index_q);

	assign emit   = cur_valid_q && hit && (!out_valid || !out_stall);
	assign finish = cur_valid_q && (!hit || (emit && !more));
	assign q_pop  = q_valid && (!cur_valid_q || finish);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q     <= '0;
			index_q     <= '0;
			made_q      <= '0;
			run_cnt_q   <= '0;
			cur_valid_q <= 1'b0;
		end else begin
			// A first sample restarts every counter before its own outputs are decided.
			if (q_pop && q_head.first) begin
				accum_q <= '0;
				index_q <= '0;
				made_q  <= '0;
			end else begin
				if (emit) begin
					accum_q <= accum_nxt;
					made_q  <= made_nxt;
				end
				if (finish) begin
					index_q <= index_q + COUNT_BITS'(1);
				end
			end
			if (q_pop || finish) begin
				run_cnt_q <= '0;
			end else if (emit) begin
				run_cnt_q <= run_cnt_q + nnr_pkg::RUN_CNT_W'(1);
			end
			if (q_pop) begin
				cur_valid_q <= 1'b1;
			end else if (finish) begin
				cur_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_value_q <= q_head.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (emit) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_value  <= cur_value_q;
			run_end    <= !more;
			sound_done <= (CMP_W'(made_nxt) == total_ext);
		end
	end

endmodule

// File: sv/nnr_checker.sv
// Port-level checks of the nearest-neighbor resampler, bound to its top level.
`include "nearest_neighbor_resampler_defines.svh"

module nnr_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic signed [nnr_pkg::SAMPLE_W-1:0] out_value,
	input logic                                run_end,
	input logic                                sound_done
);

	// A stalled result stays presented and unchanged.
	`NNR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_value) && $stable(run_end) && $stable(sound_done))

	// The final output of a sound always closes the run of its source sample.
	`NNR_ASSERT_IMPLY(a_done_ends_run, out_valid && sound_done, run_end)

	// Inside a run the next result is ready as soon as the current one is taken.
	`NNR_ASSERT_NEXT(a_run_continues, out_valid && !run_end, out_valid)

endmodule

bind nearest_neighbor_resampler nnr_checker u_nnr_checker (.*);
